### hdl/ssu_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted set union / intersection unit.
// Depends on nothing; imported by every module of the block.
package ssu_pkg;

   localparam int DATA_W = 32;

   localparam logic [1:0] OP_PUSH_FIRST  = 2'd0;
   localparam logic [1:0] OP_PUSH_SECOND = 2'd1;
   localparam logic [1:0] OP_RUN         = 2'd2;

   localparam logic MODE_UNION     = 1'b0;
   localparam logic MODE_INTERSECT = 1'b1;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

### hdl/sorted_set_union_intersection_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted set union / intersection unit with its sequencer.
// Depends on ssu_pkg, ssu_list_mem and ssu_cmp.
//
// Items arrive on the req channel: req_tuser selects push to the first list,
// push to the second list or run, and req_tdata carries the value to push.
// Pushes are taken one per cycle; a push to a full list is dropped and sets
// the overflow flag. A run sorts both lists and merges them, emitting the
// union (mode 0) or the intersection (mode 1) on the rsp channel in ascending
// order, with tlast on the final item. An empty result gives one item with
// present low. The run then clears both lists and the overflow flag.
// While a run is in progress req_tready is low. Every compare, in the sort and
// in the merge, goes through the one shared comparator, and each list memory
// has a single read and a single write port, so each merge compare step passes
// through a read state and then a compare state.
// The mode register is written on the csr channel, which is always ready.
// Synchronous reset empties both lists, clears overflow and sets mode 0.
// A stalled rsp receiver holds the result register and pauses the merge.
module sorted_set_union_intersection_unit
   import ssu_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic signed [DATA_W-1:0] req_tdata,   // value
   input  logic [1:0]               req_tuser,   // opcode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic signed [DATA_W-1:0] rsp_tdata,   // result_value
   output logic [1:0]               rsp_tuser,   // present, overflow
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_START,
      ST_SORT_HOLD,
      ST_SORT_STEP,
      ST_SORT_LAST,
      ST_MERGE_READ,
      ST_MERGE_CMP,
      ST_MERGE_FIN
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic                     dropped_ff, dropped_in;
   logic                     mode_ff, mode_in;
   logic                     sel_ff, sel_in;
   logic [CW-1:0]            limit_ff, limit_in;
   logic [CW-1:0]            k_ff, k_in;
   logic [CW-1:0]            c_ff, c_in, d_ff, d_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic signed [DATA_W-1:0] pend_value_ff, pend_value_in;
   logic signed [DATA_W-1:0] hold_ff, hold_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_present_ff, rsp_present_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_overflow_ff, rsp_overflow_in;

   logic                     m1_we, m2_we;
   logic [AW-1:0]            m1_waddr, m2_waddr, m1_raddr, m2_raddr;
   logic signed [DATA_W-1:0] m1_wdata, m2_wdata, rd1, rd2;

   logic                     sort_we;
   logic [AW-1:0]            sort_waddr, sort_raddr;
   logic signed [DATA_W-1:0] sort_wdata, sort_rd;
   logic [CW-1:0]            k_next, k_prev, limit_prev;

   logic                     merging, slot_free;
   logic                     a_rem, b_rem, emit, advance_c, advance_d, done;
   logic signed [DATA_W-1:0] emit_value;
   logic signed [DATA_W-1:0] cmp_a, cmp_b;
   cmp_res_type              cmp_res;

   ssu_list_mem #(.DEPTH(DEPTH)) u_first_mem (
      .clock   (clock),
      .wr_en   (m1_we),
      .wr_addr (m1_waddr),
      .wr_data (m1_wdata),
      .rd_addr (m1_raddr),
      .rd_data (rd1)
   );

   ssu_list_mem #(.DEPTH(DEPTH)) u_second_mem (
      .clock   (clock),
      .wr_en   (m2_we),
      .wr_addr (m2_waddr),
      .wr_data (m2_wdata),
      .rd_addr (m2_raddr),
      .rd_data (rd2)
   );

   ssu_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign merging    = (state_ff == ST_MERGE_READ) || (state_ff == ST_MERGE_CMP);
   assign sort_rd    = sel_ff ? rd2 : rd1;
   assign cmp_a      = merging ? rd1 : sort_rd;
   assign cmp_b      = merging ? rd2 : hold_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign k_next     = k_ff + ONE_C;
   assign k_prev     = k_ff - ONE_C;
   assign limit_prev = limit_ff - ONE_C;
   assign a_rem      = (c_ff < cnt1_ff);
   assign b_rem      = (d_ff < cnt2_ff);

   always_comb begin
      emit       = 1'b0;
      advance_c  = 1'b0;
      advance_d  = 1'b0;
      done       = 1'b0;
      emit_value = rd2;
      if (a_rem && b_rem) begin
         if (cmp_res.lt) begin
            emit       = (mode_ff == MODE_UNION);
            emit_value = rd1;
            advance_c  = 1'b1;
         end else if (cmp_res.eq) begin
            emit      = 1'b1;
            advance_c = 1'b1;
            advance_d = 1'b1;
         end else begin
            emit      = (mode_ff == MODE_UNION);
            advance_d = 1'b1;
         end
      end else if ((mode_ff == MODE_UNION) && a_rem) begin
         emit       = 1'b1;
         emit_value = rd1;
         advance_c  = 1'b1;
      end else if ((mode_ff == MODE_UNION) && b_rem) begin
         emit      = 1'b1;
         advance_d = 1'b1;
      end else begin
         done = 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cnt1_in         = cnt1_ff;
      cnt2_in         = cnt2_ff;
      dropped_in      = dropped_ff;
      mode_in         = csr_valid ? csr_data : mode_ff;
      sel_in          = sel_ff;
      limit_in        = limit_ff;
      k_in            = k_ff;
      c_in            = c_ff;
      d_in            = d_ff;
      pend_valid_in   = pend_valid_ff;
      pend_value_in   = pend_value_ff;
      hold_in         = hold_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_value_in    = rsp_value_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_overflow_in = rsp_overflow_ff;
      m1_we           = 1'b0;
      m2_we           = 1'b0;
      m1_waddr        = '0;
      m2_waddr        = '0;
      m1_wdata        = req_tdata;
      m2_wdata        = req_tdata;
      m1_raddr        = '0;
      m2_raddr        = '0;
      sort_we         = 1'b0;
      sort_waddr      = '0;
      sort_wdata      = hold_ff;
      sort_raddr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  OP_PUSH_FIRST: begin
                     if (cnt1_ff < DEPTH_C) begin
                        m1_we    = 1'b1;
                        m1_waddr = cnt1_ff[AW-1:0];
                        cnt1_in  = cnt1_ff + ONE_C;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_PUSH_SECOND: begin
                     if (cnt2_ff < DEPTH_C) begin
                        m2_we    = 1'b1;
                        m2_waddr = cnt2_ff[AW-1:0];
                        cnt2_in  = cnt2_ff + ONE_C;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     sel_in   = 1'b0;
                     limit_in = cnt1_ff;
                     state_in = ST_SORT_START;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SORT_START: begin
            if (limit_ff < TWO_C) begin
               if (!sel_ff) begin
                  sel_in   = 1'b1;
                  limit_in = cnt2_ff;
               end else begin
                  c_in     = '0;
                  d_in     = '0;
                  state_in = ST_MERGE_READ;
               end
            end else begin
               sort_raddr = '0;
               state_in   = ST_SORT_HOLD;
            end
         end
         ST_SORT_HOLD: begin
            hold_in    = sort_rd;
            k_in       = ONE_C;
            sort_raddr = ONE_C[AW-1:0];
            state_in   = ST_SORT_STEP;
         end
         ST_SORT_STEP: begin
            sort_we    = 1'b1;
            sort_waddr = k_prev[AW-1:0];
            if (cmp_res.lt) begin
               sort_wdata = sort_rd;
            end else begin
               sort_wdata = hold_ff;
               hold_in    = sort_rd;
            end
            k_in = k_next;
            if (k_next < limit_ff) begin
               sort_raddr = k_next[AW-1:0];
            end else begin
               state_in = ST_SORT_LAST;
            end
         end
         ST_SORT_LAST: begin
            sort_we    = 1'b1;
            sort_waddr = limit_prev[AW-1:0];
            sort_wdata = hold_ff;
            limit_in   = limit_prev;
            state_in   = ST_SORT_START;
         end
         ST_MERGE_READ: begin
            m1_raddr = c_ff[AW-1:0];
            m2_raddr = d_ff[AW-1:0];
            state_in = ST_MERGE_CMP;
         end
         ST_MERGE_CMP: begin
            m1_raddr = c_ff[AW-1:0];
            m2_raddr = d_ff[AW-1:0];
            if (done) begin
               state_in = ST_MERGE_FIN;
            end else if (!(emit && pend_valid_ff && !slot_free)) begin
               if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_value_in    = pend_value_ff;
                     rsp_present_in  = 1'b1;
                     rsp_last_in     = 1'b0;
                     rsp_overflow_in = dropped_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_value_in = emit_value;
               end
               if (advance_c) begin
                  c_in = c_ff + ONE_C;
               end
               if (advance_d) begin
                  d_in = d_ff + ONE_C;
               end
               state_in = ST_MERGE_READ;
            end
         end
         ST_MERGE_FIN: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = pend_valid_ff ? pend_value_ff : '0;
               rsp_present_in  = pend_valid_ff;
               rsp_last_in     = 1'b1;
               rsp_overflow_in = dropped_ff;
               pend_valid_in   = 1'b0;
               cnt1_in         = '0;
               cnt2_in         = '0;
               dropped_in      = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_SORT_START || state_ff == ST_SORT_HOLD || state_ff == ST_SORT_STEP) begin
         m1_raddr = sort_raddr;
         m2_raddr = sort_raddr;
      end
      if (sort_we) begin
         if (sel_ff) begin
            m2_we    = 1'b1;
            m2_waddr = sort_waddr;
            m2_wdata = sort_wdata;
         end else begin
            m1_we    = 1'b1;
            m1_waddr = sort_waddr;
            m1_wdata = sort_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         dropped_ff    <= 1'b0;
         mode_ff       <= MODE_UNION;
         sel_ff        <= 1'b0;
         limit_ff      <= '0;
         k_ff          <= '0;
         c_ff          <= '0;
         d_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt1_ff       <= cnt1_in;
         cnt2_ff       <= cnt2_in;
         dropped_ff    <= dropped_in;
         mode_ff       <= mode_in;
         sel_ff        <= sel_in;
         limit_ff      <= limit_in;
         k_ff          <= k_in;
         c_ff          <= c_in;
         d_ff          <= d_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_value_ff   <= pend_value_in;
      hold_ff         <= hold_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_overflow_ff, rsp_present_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_RUN) |=> !req_tready)
      else $error("Input still ready after a run item was accepted.");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("Pending result left behind after a run.");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE_FIN && slot_free) |=>
      (rsp_tvalid && rsp_tlast && cnt1_ff == '0 && cnt2_ff == '0 && !dropped_ff))
      else $error("Run finished without a final item or without clearing the lists.");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("Empty-result item is not marked last.");

endmodule

### hdl/ssu_list_mem.sv
`timescale 1ns / 1ps
// List storage: one write port and one read port with registered read data.
// Depends on ssu_pkg for the data width.
module ssu_list_mem
   import ssu_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic signed [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic signed [DATA_W-1:0]          rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hdl/ssu_cmp.sv
`timescale 1ns / 1ps
// Shared signed comparator used by both the sort and the merge steps.
// Depends on ssu_pkg for the data width and the result struct.
module ssu_cmp
   import ssu_pkg::*;
(
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output cmp_res_type              res
);

   assign res.lt = (a < b);
   assign res.eq = (a == b);

endmodule

### bench/sorted_set_union_intersection_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_set_union_intersection_unit: a directed table, then random
// push/run groups with bursty input and a stalling receiver, checked against an inline model.
// Depends on ssu_pkg and the RTL of the unit only.
module sorted_set_union_intersection_unit_tb;
   import ssu_pkg::*;

   localparam int DEPTH = 16;
   localparam int CLK_PERIOD = 12;
   localparam int ITEM_TARGET = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 50;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

   typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     present;
      logic                     last;
      logic                     overflow;
   } merged_item_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [1:0]               op;
      logic signed [DATA_W-1:0] value;
      logic                     fixed_exp;
      logic signed [DATA_W-1:0] exp_value;
      logic                     exp_present;
      logic                     exp_last;
      logic                     exp_overflow;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic signed [DATA_W-1:0] req_tdata;   // value
   logic [1:0]               req_tuser;   // opcode
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic signed [DATA_W-1:0] rsp_tdata;   // result_value
   logic [1:0]               rsp_tuser;   // present, overflow
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic                     csr_data;

   logic signed [DATA_W-1:0] set_vals [0:1][0:DEPTH-1];
   int                       set_count [0:1];
   logic                     drop_seen;
   logic                     cur_mode;
   merged_item_type          merged_due [$];
   stim_row_type             directed_rows [$];
   int                       mismatch_count;
   int                       burst_left;
   int                       hold_asks;

   sorted_set_union_intersection_unit #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("FAILURE");
      $finish;
   end

   // Lists are kept in ascending order as they are filled, so a run only merges.
   task automatic apply_item(input logic [1:0] op, input logic signed [DATA_W-1:0] v,
                             input logic fixed_exp, input merged_item_type fixed_res);
      int                       sel;
      int                       k;
      int                       c;
      int                       d;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] merged [$];
      merged_item_type          r;
      if (op == OP_PUSH_FIRST || op == OP_PUSH_SECOND) begin
         sel = (op == OP_PUSH_SECOND) ? 1 : 0;
         if (set_count[sel] < DEPTH) begin
            k = set_count[sel];
            while (k > 0 && set_vals[sel][k-1] > v) begin
               set_vals[sel][k] = set_vals[sel][k-1];
               k--;
            end
            set_vals[sel][k] = v;
            set_count[sel]++;
         end else begin
            drop_seen = 1'b1;
         end
      end else if (op == OP_RUN) begin
         c = 0;
         d = 0;
         while (c < set_count[0] && d < set_count[1]) begin
            a = set_vals[0][c];
            b = set_vals[1][d];
            if (a < b) begin
               if (cur_mode == MODE_UNION) merged.push_back(a);
               c++;
            end else if (b < a) begin
               if (cur_mode == MODE_UNION) merged.push_back(b);
               d++;
            end else begin
               merged.push_back(b);
               c++;
               d++;
            end
         end
         if (cur_mode == MODE_UNION) begin
            while (c < set_count[0]) begin
               merged.push_back(set_vals[0][c]);
               c++;
            end
            while (d < set_count[1]) begin
               merged.push_back(set_vals[1][d]);
               d++;
            end
         end
         if (fixed_exp) begin
            merged_due.push_back(fixed_res);
         end else if (merged.size() == 0) begin
            r.value = '0;
            r.present = 1'b0;
            r.last = 1'b1;
            r.overflow = drop_seen;
            merged_due.push_back(r);
         end else begin
            for (k = 0; k < merged.size(); k++) begin
               r.value = merged[k];
               r.present = 1'b1;
               r.last = (k == merged.size() - 1);
               r.overflow = drop_seen;
               merged_due.push_back(r);
            end
         end
         set_count[0] = 0;
         set_count[1] = 0;
         drop_seen = 1'b0;
      end
   endtask

   task automatic drive_item(input logic [1:0] op, input logic signed [DATA_W-1:0] v,
                             input logic fixed_exp, input merged_item_type fixed_res);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      apply_item(op, v, fixed_exp, fixed_res);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (merged_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_data <= m;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   initial begin
      int seg_left;
      int seg_kind;
      int hold_left;
      int hold_served;
      int phase;
      rsp_tready = 1'b0;
      seg_left = 0;
      seg_kind = 0;
      hold_left = 0;
      hold_served = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_served != hold_asks) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(0, 3);
               seg_left = $urandom_range(10, 120);
            end
            seg_left--;
            phase++;
            case (seg_kind)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= (phase % 3 == 0);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      merged_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (merged_due.size() == 0) begin
            $error("unexpected result item, result_value %0d", rsp_tdata);
            mismatch_count++;
         end else begin
            want = merged_due.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("result_value: expected %0d, actual %0d", want.value, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.present) begin
               $error("present: expected %0b, actual %0b", want.present, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow, rsp_tuser[1]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int                       i;
      int                       grp;
      int                       n_first;
      int                       n_second;
      int                       pick;
      int                       issued;
      logic [1:0]               op;
      logic signed [DATA_W-1:0] v;
      stim_row_type             row;
      merged_item_type          fixed_res;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_PUSH_FIRST;
      csr_valid = 1'b0;
      csr_data = MODE_UNION;
      set_count[0] = 0;
      set_count[1] = 0;
      drop_seen = 1'b0;
      cur_mode = MODE_UNION;
      mismatch_count = 0;
      burst_left = 0;
      hold_asks = 0;

      directed_rows.push_back('{ROW_ITEM, OP_RUN, 32'sd0, 1'b1, 32'sd0, 1'b0, 1'b1, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_FIRST, S_MAX, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_FIRST, S_MIN, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_FIRST, 32'sd5, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_FIRST, 32'sd5, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_UNUSED, 32'sh5a5a_a5a5, 1'b0, 32'sd0, 1'b0, 1'b0,
                                1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_SECOND, 32'sd5, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_SECOND, S_MIN, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_RUN, 32'sd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_MODE, OP_RUN, {31'd0, MODE_INTERSECT}, 1'b0, 32'sd0, 1'b0,
                                1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_FIRST, -32'sd1, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_PUSH_SECOND, S_MAX, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{ROW_ITEM, OP_RUN, 32'sd0, 1'b1, 32'sd0, 1'b0, 1'b1, 1'b0});
      for (i = 0; i <= DEPTH; i++) begin
         directed_rows.push_back('{ROW_ITEM, OP_PUSH_SECOND, i - 8, 1'b0, 32'sd0, 1'b0, 1'b0,
                                   1'b0});
      end
      directed_rows.push_back('{ROW_ITEM, OP_RUN, 32'sd0, 1'b1, 32'sd0, 1'b0, 1'b1, 1'b1});
      directed_rows.push_back('{ROW_MODE, OP_RUN, {31'd0, MODE_UNION}, 1'b0, 32'sd0, 1'b0, 1'b0,
                                1'b0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_MODE) begin
            write_mode(row.value[0]);
         end else begin
            fixed_res = '{row.exp_value, row.exp_present, row.exp_last, row.exp_overflow};
            drive_item(row.op, row.value, row.fixed_exp, fixed_res);
         end
      end

      issued = 0;
      grp = 0;
      while (issued < ITEM_TARGET) begin
         if (grp > 0 && $urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
         if (grp == 3) hold_asks <= hold_asks + 1;
         if (grp == 6) drain_results();
         n_first = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 8);
         n_second = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 8);
         while (n_first + n_second > 0) begin
            if ($urandom_range(0, 19) == 0) drive_item(OP_UNUSED, $urandom(), 1'b0, '0);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               v = $urandom_range(0, 12) - 6;
            end else if (pick < 8) begin
               v = $urandom();
            end else begin
               case ($urandom_range(0, 3))
                  0: v = S_MIN;
                  1: v = S_MAX;
                  2: v = -32'sd1;
                  default: v = 32'sd0;
               endcase
            end
            if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1) == 1)) begin
               op = OP_PUSH_FIRST;
               n_first--;
            end else begin
               op = OP_PUSH_SECOND;
               n_second--;
            end
            drive_item(op, v, 1'b0, '0);
            issued++;
         end
         // Now and then a group ends without a run, so the next group adds to the same lists.
         if ($urandom_range(0, 7) != 0) begin
            drive_item(OP_RUN, $urandom(), 1'b0, '0);
            issued++;
         end
         grp++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/ssu_pkg.sv
hdl/ssu_list_mem.sv
hdl/ssu_cmp.sv
hdl/sorted_set_union_intersection_unit.sv
bench/sorted_set_union_intersection_unit_tb.sv
